// ----- rtl/scd_pkg.sv -----
// ----------------------------------------------------------------------------
// scd_pkg
// Shared widths, reset values, codes and controller/datapath handshake types
// for the stove cooking event detector.
// ----------------------------------------------------------------------------
package scd_pkg;

   // Window depth and field widths
   localparam int WINDOW_DEPTH = 8;
   localparam int TEMP_W       = 12;
   localparam int GRAD_W       = 13;
   localparam int TIME_W       = 32;
   localparam int DUR_W        = 16;
   localparam int PCT_W        = 7;

   // Configuration port
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;

   // Derived widths
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
   localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
   localparam int TSUM_W       = TEMP_W + FILL_W;
   localparam int GSUM_W       = GRAD_W + FILL_W;
   localparam int PROD_W       = TEMP_W + PCT_W + 1;
   localparam int DIV_W        = (GSUM_W > TSUM_W) ? GSUM_W : TSUM_W;
   localparam int DVS_W        = FILL_W;
   localparam int DIV_CNT_W    = $clog2(DIV_W + 1);

   // Stop temperature scaling: round(peak * percent / 100)
   localparam int PCT_SCALE    = 100;
   localparam int ROUND_HALF   = PCT_SCALE / 2;

   // Divide by 100 as a reciprocal multiply; exact for numerators below
   // 2^STOP_SHIFT / 68, well above the largest rounded product
   localparam int STOP_SHIFT   = 25;
   localparam int RECIP_W      = STOP_SHIFT - $clog2(PCT_SCALE) + 1;
   localparam int SCALE_W      = PROD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] STOP_RECIP =
      RECIP_W'((2 ** STOP_SHIFT + PCT_SCALE - 1) / PCT_SCALE);

   // Register reset values
   localparam logic signed [TEMP_W-1:0] START_TEMP_RST = TEMP_W'(75);
   localparam logic signed [GRAD_W-1:0] START_GRAD_RST = GRAD_W'(10);
   localparam logic        [PCT_W-1:0]  STOP_PCT_RST   = PCT_W'(36);
   localparam logic signed [GRAD_W-1:0] STOP_GRAD_RST  = GRAD_W'(1);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_TEMP = 2'd0,
      CSR_START_GRAD = 2'd1,
      CSR_STOP_PCT   = 2'd2,
      CSR_STOP_GRAD  = 2'd3
   } csr_index_type;

   // Divider operand selection
   typedef enum logic {
      DIV_SEL_TEMP,
      DIV_SEL_GRAD
   } div_sel_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_TDIV_GO,
      ST_TDIV_WAIT,
      ST_GDIV_GO,
      ST_GDIV_WAIT,
      ST_MULT,
      ST_SCALE,
      ST_COMMIT
   } scd_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        load;
      logic        sweep;
      logic        div_start;
      div_sel_type div_sel;
      logic        mult;
      logic        scale;
      logic        commit;
   } scd_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic sweep_done;
      logic div_done;
   } scd_status_type;

endpackage

// ----- rtl/scd_req_if.sv -----
// ----------------------------------------------------------------------------
// scd_req_if
// Sample channel: one thermocouple reading with timestamp and clock flag.
// ----------------------------------------------------------------------------
interface scd_req_if import scd_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] sample_temp;
   logic        [TIME_W-1:0] now_time;
   logic                     clock_valid;

   modport source (output valid, sample_temp, now_time, clock_valid, input ready);
   modport sink   (input valid, sample_temp, now_time, clock_valid, output ready);

endinterface

// ----- rtl/scd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// scd_rsp_if
// Result channel: stove state, window averages and session end events.
// ----------------------------------------------------------------------------
interface scd_rsp_if import scd_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic                     cooking;
   logic                     detection_ran;
   logic signed [TEMP_W-1:0] avg_temp;
   logic signed [GRAD_W-1:0] avg_gradient;
   logic                     event_valid;
   logic        [TIME_W-1:0] event_start;
   logic        [DUR_W-1:0]  event_duration;
   logic signed [TEMP_W-1:0] event_peak;

   modport source (output valid, cooking, detection_ran, avg_temp, avg_gradient,
                   event_valid, event_start, event_duration, event_peak,
                   input ready);
   modport sink   (input valid, cooking, detection_ran, avg_temp, avg_gradient,
                   event_valid, event_start, event_duration, event_peak,
                   output ready);

endinterface

// ----- rtl/scd_divider.sv -----
// ----------------------------------------------------------------------------
// scd_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scd_divider import scd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     acc_ff;
   logic [DVS_W-1:0]     rem_ff;
   logic [DVS_W-1:0]     dvs_ff;

   logic [DVS_W:0]       shifted;
   logic [DVS_W:0]       trial;
   logic                 fits;

   // Shift in the next dividend bit and try the subtract
   always_comb begin
      shifted = {rem_ff, acc_ff[DIV_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
   end

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = acc_ff;

   // Step count and busy flag
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Quotient bits shift in as dividend bits shift out
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff && (cnt_ff != '0)) begin
         acc_ff <= {acc_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      end
   end

endmodule

// ----- rtl/scd_datapath.sv -----
// ----------------------------------------------------------------------------
// scd_datapath
// Sample and gradient windows, window sums, shared divider, stop temperature,
// session state and the result register.
// ----------------------------------------------------------------------------
module scd_datapath import scd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  scd_cmd_type              cmd,
   output scd_status_type           status,
   input  logic signed [TEMP_W-1:0] sample_temp,
   input  logic        [TIME_W-1:0] now_time,
   input  logic                     clock_valid,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output logic                     rsp_cooking,
   output logic                     rsp_detection_ran,
   output logic signed [TEMP_W-1:0] rsp_avg_temp,
   output logic signed [GRAD_W-1:0] rsp_avg_gradient,
   output logic                     rsp_event_valid,
   output logic        [TIME_W-1:0] rsp_event_start,
   output logic        [DUR_W-1:0]  rsp_event_duration,
   output logic signed [TEMP_W-1:0] rsp_event_peak
);

   // Configuration
   logic signed [TEMP_W-1:0] start_temp_ff;
   logic signed [GRAD_W-1:0] start_grad_ff;
   logic        [PCT_W-1:0]  stop_pct_ff;
   logic signed [GRAD_W-1:0] stop_grad_ff;

   // Windows
   logic signed [TEMP_W-1:0] temp_mem [WINDOW_DEPTH];
   logic signed [GRAD_W-1:0] grad_mem [WINDOW_DEPTH];
   logic [WIN_AW-1:0]        temp_head_ff, grad_head_ff;
   logic [FILL_W-1:0]        temp_fill_ff, grad_fill_ff;
   logic signed [TEMP_W-1:0] last_temp_ff;
   logic signed [GRAD_W-1:0] diff;

   // Current sample
   logic [TIME_W-1:0]        now_ff;
   logic                     clk_ok_ff;

   // Sum sweep
   logic [FILL_W-1:0]        idx_ff;
   logic                     pend_t_ff, pend_g_ff;
   logic signed [TEMP_W-1:0] trd_ff;
   logic signed [GRAD_W-1:0] grd_ff;
   logic signed [TSUM_W-1:0] tsum_ff;
   logic signed [GSUM_W-1:0] gsum_ff;

   // Averages and stop temperature
   logic signed [TEMP_W-1:0] avg_t_ff;
   logic signed [GRAD_W-1:0] avg_g_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [GRAD_W-1:0] stop_t_ff;

   // Session state
   logic                     cooking_ff;
   logic signed [TEMP_W-1:0] peak_ff;
   logic [TIME_W-1:0]        sess_start_ff;

   // Divider connections
   logic [TSUM_W-1:0]        tsum_mag;
   logic [GSUM_W-1:0]        gsum_mag;
   logic [DIV_W-1:0]         div_dividend;
   logic [DVS_W-1:0]         div_divisor;
   logic                     div_done;
   logic [DIV_W-1:0]         div_q;
   logic [DIV_W-1:0]         div_q_neg;

   // Stop temperature scaling
   logic [PROD_W-1:0]        prod_mag;
   logic [PROD_W-1:0]        stop_num;
   logic [SCALE_W-1:0]       stop_scaled;
   logic [GRAD_W-1:0]        stop_q;

   // Decision
   logic signed [TEMP_W-1:0] peak_cand;
   logic                     ran;
   logic                     go_start;
   logic                     go_stop;
   logic [TIME_W-1:0]        elapsed;
   logic [DUR_W-1:0]         duration;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_temp_ff <= START_TEMP_RST;
         start_grad_ff <= START_GRAD_RST;
         stop_pct_ff   <= STOP_PCT_RST;
         stop_grad_ff  <= STOP_GRAD_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_TEMP: start_temp_ff <= csr_wdata[TEMP_W-1:0];
            CSR_START_GRAD: start_grad_ff <= csr_wdata[GRAD_W-1:0];
            CSR_STOP_PCT:   stop_pct_ff   <= csr_wdata[PCT_W-1:0];
            CSR_STOP_GRAD:  stop_grad_ff  <= csr_wdata[GRAD_W-1:0];
            default: ;
         endcase
      end
   end

   assign diff = GRAD_W'(sample_temp) - GRAD_W'(last_temp_ff);

   // Window memories: write the new entries, read one entry per sweep cycle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         temp_mem[temp_head_ff] <= sample_temp;
         if (temp_fill_ff != '0) begin
            grad_mem[grad_head_ff] <= diff;
         end
      end
      if (cmd.sweep) begin
         trd_ff <= temp_mem[idx_ff[WIN_AW-1:0]];
         grd_ff <= grad_mem[idx_ff[WIN_AW-1:0]];
      end
   end

   assign status.sweep_done = cmd.sweep && (idx_ff == temp_fill_ff);
   assign status.div_done   = div_done;

   // Window pointers, fill counts and sweep control
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_head_ff <= '0;
         temp_fill_ff <= '0;
         grad_head_ff <= '0;
         grad_fill_ff <= '0;
         idx_ff       <= '0;
         pend_t_ff    <= 1'b0;
         pend_g_ff    <= 1'b0;
      end else if (cmd.load) begin
         temp_head_ff <= (temp_head_ff == WIN_AW'(WINDOW_DEPTH - 1)) ? '0
                                                                    : temp_head_ff + 1'b1;
         if (temp_fill_ff != FILL_W'(WINDOW_DEPTH)) begin
            temp_fill_ff <= temp_fill_ff + 1'b1;
         end
         if (temp_fill_ff != '0) begin
            grad_head_ff <= (grad_head_ff == WIN_AW'(WINDOW_DEPTH - 1)) ? '0
                                                                       : grad_head_ff + 1'b1;
            if (grad_fill_ff != FILL_W'(WINDOW_DEPTH)) begin
               grad_fill_ff <= grad_fill_ff + 1'b1;
            end
         end
         idx_ff    <= '0;
         pend_t_ff <= 1'b0;
         pend_g_ff <= 1'b0;
      end else if (cmd.sweep && (idx_ff < temp_fill_ff)) begin
         idx_ff    <= idx_ff + 1'b1;
         pend_t_ff <= 1'b1;
         pend_g_ff <= (idx_ff < grad_fill_ff);
      end else begin
         pend_t_ff <= 1'b0;
         pend_g_ff <= 1'b0;
      end
   end

   // Capture the sample and accumulate window sums
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         last_temp_ff <= sample_temp;
         now_ff       <= now_time;
         clk_ok_ff    <= clock_valid;
         tsum_ff      <= '0;
         gsum_ff      <= '0;
      end else begin
         if (pend_t_ff) begin
            tsum_ff <= tsum_ff + TSUM_W'(trd_ff);
         end
         if (pend_g_ff) begin
            gsum_ff <= gsum_ff + GSUM_W'(grd_ff);
         end
      end
   end

   // Select divider operands: magnitudes, sign restored on capture
   always_comb begin
      tsum_mag = tsum_ff[TSUM_W-1] ? TSUM_W'(-tsum_ff) : TSUM_W'(tsum_ff);
      gsum_mag = gsum_ff[GSUM_W-1] ? GSUM_W'(-gsum_ff) : GSUM_W'(gsum_ff);
      case (cmd.div_sel)
         DIV_SEL_TEMP: begin
            div_dividend = DIV_W'(tsum_mag);
            div_divisor  = DVS_W'(temp_fill_ff);
         end
         default: begin
            div_dividend = DIV_W'(gsum_mag);
            div_divisor  = DVS_W'(grad_fill_ff);
         end
      endcase
   end

   scd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign div_q_neg = ~div_q + 1'b1;

   // Round the product magnitude and divide by 100 (20 x 19 bit multiply)
   always_comb begin
      prod_mag    = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      stop_num    = prod_mag + PROD_W'(ROUND_HALF);
      stop_scaled = SCALE_W'(stop_num) * SCALE_W'(STOP_RECIP);
      stop_q      = stop_scaled[STOP_SHIFT +: GRAD_W];
   end

   // Peak raised by the current average while cooking
   assign peak_cand = (cooking_ff && (avg_t_ff > peak_ff)) ? avg_t_ff : peak_ff;

   // Capture quotients, form the percent product and the stop temperature
   always_ff @(posedge clock) begin
      if (div_done) begin
         case (cmd.div_sel)
            DIV_SEL_TEMP: begin
               avg_t_ff <= tsum_ff[TSUM_W-1] ? div_q_neg[TEMP_W-1:0] : div_q[TEMP_W-1:0];
            end
            DIV_SEL_GRAD: begin
               if (grad_fill_ff == '0) begin
                  avg_g_ff <= '0;
               end else begin
                  avg_g_ff <= gsum_ff[GSUM_W-1] ? div_q_neg[GRAD_W-1:0]
                                                : div_q[GRAD_W-1:0];
               end
            end
            default: ;
         endcase
      end
      if (cmd.mult) begin
         prod_ff <= PROD_W'(peak_cand) * PROD_W'($signed({1'b0, stop_pct_ff}));
      end
      if (cmd.scale) begin
         stop_t_ff <= prod_ff[PROD_W-1] ? -stop_q : stop_q;
      end
   end

   // Start and stop decisions
   always_comb begin
      ran      = clk_ok_ff && (temp_fill_ff == FILL_W'(WINDOW_DEPTH));
      go_start = ran && !cooking_ff && (avg_t_ff > start_temp_ff)
                 && (avg_g_ff > start_grad_ff);
      go_stop  = ran && cooking_ff && (GRAD_W'(avg_t_ff) < stop_t_ff)
                 && (avg_g_ff < stop_grad_ff);
      elapsed  = now_ff - sess_start_ff;
      if (now_ff == '0) begin
         duration = '0;
      end else if (elapsed[TIME_W-1:DUR_W] != '0) begin
         duration = '1;
      end else begin
         duration = elapsed[DUR_W-1:0];
      end
   end

   // Update session state
   always_ff @(posedge clock) begin
      if (reset) begin
         cooking_ff    <= 1'b0;
         peak_ff       <= '0;
         sess_start_ff <= '0;
      end else if (cmd.commit) begin
         if (go_start) begin
            cooking_ff    <= 1'b1;
            peak_ff       <= avg_t_ff;
            sess_start_ff <= now_ff;
         end else begin
            if (ran && cooking_ff) begin
               peak_ff <= peak_cand;
            end
            if (go_stop) begin
               cooking_ff <= 1'b0;
            end
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_cooking        <= go_start || (cooking_ff && !go_stop);
         rsp_detection_ran  <= ran;
         rsp_avg_temp       <= avg_t_ff;
         rsp_avg_gradient   <= avg_g_ff;
         rsp_event_valid    <= go_stop;
         rsp_event_start    <= go_stop ? sess_start_ff : '0;
         rsp_event_duration <= go_stop ? duration : '0;
         rsp_event_peak     <= go_stop ? peak_cand : '0;
      end
   end

endmodule

// ----- rtl/scd_ctrl.sv -----
// ----------------------------------------------------------------------------
// scd_ctrl
// Sequencer: accepts a sample, steps the datapath through sweep, divides and
// multiplies, then commits the result when the output register is free.
// ----------------------------------------------------------------------------
module scd_ctrl import scd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output scd_cmd_type    cmd,
   input  scd_status_type status
);

   scd_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = DIV_SEL_TEMP;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_TDIV_GO;
            end
         end
         ST_TDIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_TDIV_WAIT;
         end
         ST_TDIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_GDIV_GO;
            end
         end
         ST_GDIV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_GRAD;
            state_in      = ST_GDIV_WAIT;
         end
         ST_GDIV_WAIT: begin
            cmd.div_sel = DIV_SEL_GRAD;
            if (status.div_done) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Hold the result until transfer, reload on commit
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/stove_cooking_event_detector_top.sv -----
// ----------------------------------------------------------------------------
// stove_cooking_event_detector_top
// Detects cooking sessions from periodic thermocouple samples and reports
// session start, duration and peak temperature when a session ends.
// ----------------------------------------------------------------------------
// Each sample transfer yields exactly one result. From its transfer to its
// result being loaded, a sample goes through a sweep over the window
// memories that reads one entry per cycle, then one shared 17-step restoring
// divider forms the average temperature and the average gradient in turn,
// and the rounded stop temperature is formed by a percent multiply and a
// reciprocal multiply for the divide by 100, before the commit. The next
// sample can be taken once the result is loaded, while that result waits in
// the output register; a sample is not taken while the previous one is in
// work, and a result still waiting at commit time holds the block until it
// transfers. Configuration writes take effect at once and belong between
// samples.
module stove_cooking_event_detector_top import scd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   scd_req_if.sink               req_ch,
   scd_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   scd_cmd_type    cmd;
   scd_status_type status;

   scd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   scd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .sample_temp        (req_ch.sample_temp),
      .now_time           (req_ch.now_time),
      .clock_valid        (req_ch.clock_valid),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_cooking        (rsp_ch.cooking),
      .rsp_detection_ran  (rsp_ch.detection_ran),
      .rsp_avg_temp       (rsp_ch.avg_temp),
      .rsp_avg_gradient   (rsp_ch.avg_gradient),
      .rsp_event_valid    (rsp_ch.event_valid),
      .rsp_event_start    (rsp_ch.event_start),
      .rsp_event_duration (rsp_ch.event_duration),
      .rsp_event_peak     (rsp_ch.event_peak)
   );

endmodule

// ----- rtl/scd_checker.sv -----
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks for the stove cooking event detector.
// ----------------------------------------------------------------------------
module scd_checker import scd_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_cooking,
   input logic                     rsp_detection_ran,
   input logic                     rsp_event_valid,
   input logic        [TIME_W-1:0] rsp_event_start,
   input logic        [DUR_W-1:0]  rsp_event_duration,
   input logic signed [TEMP_W-1:0] rsp_event_peak
);

   // One sample in flight: no second transfer right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sample taken while the previous one is in work");

   // An event ends a session, so detection ran and the stove is idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_valid) |-> (rsp_detection_ran && !rsp_cooking))
      else $error("event without a detection step ending the session");

   // Event fields read zero without an event
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_event_valid) |->
         (rsp_event_start == '0 && rsp_event_duration == '0 && rsp_event_peak == '0))
      else $error("event fields set without an event");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cooking)
                                     && $stable(rsp_event_valid)))
      else $error("stalled result changed");

endmodule

bind stove_cooking_event_detector_top scd_checker u_scd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_cooking        (rsp_ch.cooking),
   .rsp_detection_ran  (rsp_ch.detection_ran),
   .rsp_event_valid    (rsp_ch.event_valid),
   .rsp_event_start    (rsp_ch.event_start),
   .rsp_event_duration (rsp_ch.event_duration),
   .rsp_event_peak     (rsp_ch.event_peak)
);
